// File: rtl/mten_pkg.sv
// Shared types, codes and letter tables of the multi-tap name entry block.
package mten_pkg;

   // Input operation codes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds
   localparam logic [2:0] KIND_PENDING = 3'd0;
   localparam logic [2:0] KIND_FIXED   = 3'd1;
   localparam logic [2:0] KIND_ERASED  = 3'd2;
   localparam logic [2:0] KIND_CHAR    = 3'd3;
   localparam logic [2:0] KIND_DEFAULT = 3'd4;

   // Decoded key values
   localparam logic [3:0] KEY_STAR = 4'd10;
   localparam logic [3:0] KEY_HASH = 4'd11;
   localparam logic [3:0] KEY_BAD  = 4'd12;
   localparam logic [3:0] NO_KEY   = 4'd15;

   // Matrix codes of the keypad
   localparam logic [6:0] MX_KEY1 = 7'd1;
   localparam logic [6:0] MX_KEY2 = 7'd2;
   localparam logic [6:0] MX_KEY3 = 7'd3;
   localparam logic [6:0] MX_KEY4 = 7'd11;
   localparam logic [6:0] MX_KEY5 = 7'd12;
   localparam logic [6:0] MX_KEY6 = 7'd13;
   localparam logic [6:0] MX_KEY7 = 7'd21;
   localparam logic [6:0] MX_KEY8 = 7'd22;
   localparam logic [6:0] MX_KEY9 = 7'd23;
   localparam logic [6:0] MX_KEY0 = 7'd32;
   localparam logic [6:0] MX_STAR = 7'd31;
   localparam logic [6:0] MX_HASH = 7'd33;

   localparam logic [15:0] TIMEOUT_RESET = 16'd800;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       valid;   // press of a known key
      logic [3:0] key;     // 0..9, KEY_STAR or KEY_HASH
   } key_info_type;

   // Highest tap index of a digit key
   function automatic logic [1:0] tap_last(input logic [3:0] key);
      logic [1:0] res;
      case (key)
         4'd0:    res = 2'd1;
         4'd9:    res = 2'd2;
         default: res = 2'd3;
      endcase
      return res;
   endfunction

   // Letter shown for a digit key at a tap index
   function automatic logic [7:0] tap_letter(input logic [3:0] key, input logic [1:0] tap);
      logic [7:0] res;
      res = 8'd0;
      case (key)
         4'd0: case (tap)
            2'd0:    res = " ";
            2'd1:    res = "0";
            default: res = 8'd0;
         endcase
         4'd1: case (tap)
            2'd0: res = "A"; 2'd1: res = "B"; 2'd2: res = "C"; default: res = "1";
         endcase
         4'd2: case (tap)
            2'd0: res = "D"; 2'd1: res = "E"; 2'd2: res = "F"; default: res = "2";
         endcase
         4'd3: case (tap)
            2'd0: res = "G"; 2'd1: res = "H"; 2'd2: res = "I"; default: res = "3";
         endcase
         4'd4: case (tap)
            2'd0: res = "J"; 2'd1: res = "K"; 2'd2: res = "L"; default: res = "4";
         endcase
         4'd5: case (tap)
            2'd0: res = "M"; 2'd1: res = "N"; 2'd2: res = "O"; default: res = "5";
         endcase
         4'd6: case (tap)
            2'd0: res = "P"; 2'd1: res = "Q"; 2'd2: res = "R"; default: res = "6";
         endcase
         4'd7: case (tap)
            2'd0: res = "S"; 2'd1: res = "T"; 2'd2: res = "U"; default: res = "7";
         endcase
         4'd8: case (tap)
            2'd0: res = "V"; 2'd1: res = "W"; 2'd2: res = "X"; default: res = "8";
         endcase
         4'd9: case (tap)
            2'd0:    res = "Y";
            2'd1:    res = "Z";
            2'd2:    res = "9";
            default: res = 8'd0;
         endcase
         default: res = 8'd0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/mten_decode.sv
// Keypad event decoder: press bit and matrix code to key value.
module mten_decode import mten_pkg::*; (
   input  logic [7:0]   event_code,
   output key_info_type info
);

   logic [3:0] key;

   always_comb begin
      unique case (event_code[6:0])
         MX_KEY1: key = 4'd1;
         MX_KEY2: key = 4'd2;
         MX_KEY3: key = 4'd3;
         MX_KEY4: key = 4'd4;
         MX_KEY5: key = 4'd5;
         MX_KEY6: key = 4'd6;
         MX_KEY7: key = 4'd7;
         MX_KEY8: key = 4'd8;
         MX_KEY9: key = 4'd9;
         MX_KEY0: key = 4'd0;
         MX_STAR: key = KEY_STAR;
         MX_HASH: key = KEY_HASH;
         default: key = KEY_BAD;
      endcase
   end

   // releases and unknown codes are dropped
   assign info.valid = event_code[7] && (key != KEY_BAD);
   assign info.key   = key;

endmodule

// File: rtl/multitap_name_entry_core.sv
// Top level of the multi-tap name entry block: entry state, name memory, result register.
// An accepted item sits in the input register until its processing cycle, which loads the
//   output register; that cycle waits while the output register holds an untaken result.
// The input register takes no new item until its held item is processed; '#' with n stored
//   characters then walks the name memory in a read and a send state per character (one read port).
// Reset (synchronous, active high) empties the entry, clears the handshakes and sets the
//   timeout to 800 ticks; the name memory is not cleared, only written slots are read.
module multitap_name_entry_core import mten_pkg::*; #(
   parameter int NAME_LEN = 10
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] event_code
   input  logic [0:0]  req_tuser,   // [0] operation
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] position, [11:4] character,
                                    // [15:12] name_length, [16] cursor_shown, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,   // last result of the item
   // timeout register
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(NAME_LEN + 1);                 // cursor / count width
   localparam int IW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1; // memory address width
   localparam logic [CW-1:0] NAME_MAX  = CW'(NAME_LEN);
   localparam logic [CW-1:0] LAST_SLOT = CW'(NAME_LEN - 1);

   // ---------------------------------------------------------------------------
   // Input register: one item waits here while the previous one finishes.
   // ---------------------------------------------------------------------------
   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_code_ff;
   logic       proc;          // held item is processed this cycle

   assign req_tready = !in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser[0];
         in_code_ff <= req_tdata;
      end
   end

   key_info_type key_info;

   mten_decode u_decode (
      .event_code (in_code_ff),
      .info       (key_info)
   );

   // ---------------------------------------------------------------------------
   // Entry state and timeout register
   // ---------------------------------------------------------------------------
   logic [CW-1:0] cursor_ff, cursor_in;     // count of fixed letters
   logic          pending_ff, pending_in;   // letter sits at slot cursor
   logic [3:0]    prev_ff, prev_in;         // key of the pending letter
   logic [1:0]    tap_ff, tap_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [15:0]   timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         pending_ff <= 1'b0;
         prev_ff    <= NO_KEY;
         tap_ff     <= 2'd0;
         elapsed_ff <= 16'd0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         cursor_ff  <= cursor_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
         tap_ff     <= tap_in;
         elapsed_ff <= elapsed_in;
         if (csr_wen) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Name memory: written by letter keys, read only by the '#' walk. Writes happen
   // only while idle and reads only during the walk, so the two never overlap.
   // ---------------------------------------------------------------------------
   logic [7:0]    name_mem [NAME_LEN];
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [7:0]    rd_data_ff;
   logic [CW-1:0] walk_idx_ff, walk_idx_in;
   logic [CW-1:0] walk_len_ff, walk_len_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= name_mem[walk_idx_ff[IW-1:0]];
      end
   end

   // ---------------------------------------------------------------------------
   // Walk sequencer for '#'
   // ---------------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      out_free;
   logic      out_valid_ff;
   logic      walk_start;
   logic      walk_send;
   logic      walk_last;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign walk_last = (walk_idx_ff + CW'(1)) == walk_len_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (walk_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (out_free) begin
               state_in = walk_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      proc      = 1'b0;
      rd_en     = 1'b0;
      walk_send = 1'b0;
      unique case (state_ff)
         ST_IDLE: proc      = in_valid_ff && out_free;
         ST_READ: rd_en     = 1'b1;
         ST_SEND: walk_send = out_free;
         default: proc      = 1'b0;
      endcase
   end

   always_comb begin
      walk_idx_in = walk_idx_ff;
      walk_len_in = walk_len_ff;
      if (walk_start) begin
         walk_idx_in = '0;
         walk_len_in = cursor_ff + CW'(pending_ff);
      end else if (walk_send) begin
         walk_idx_in = walk_idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      walk_idx_ff <= walk_idx_in;
      walk_len_ff <= walk_len_in;
   end

   // ---------------------------------------------------------------------------
   // Item processing: read-modify-write of the entry state
   // ---------------------------------------------------------------------------
   logic          res_ld;
   logic [2:0]    res_kind;
   logic [3:0]    res_pos;
   logic [7:0]    res_char;
   logic [3:0]    res_len;
   logic          res_shown;
   logic          res_last;
   logic [15:0]   elapsed_inc;
   logic [CW-1:0] cursor_inc;
   logic [CW-1:0] vcount;
   logic [1:0]    tap_next;
   logic [7:0]    pend_char;

   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign cursor_inc  = cursor_ff + CW'(1);
   assign vcount      = cursor_ff + CW'(pending_ff);
   assign tap_next    = (tap_ff == tap_last(prev_ff)) ? 2'd0 : tap_ff + 2'd1;
   assign pend_char   = tap_letter(prev_ff, tap_ff);

   always_comb begin
      cursor_in  = cursor_ff;
      pending_in = pending_ff;
      prev_in    = prev_ff;
      tap_in     = tap_ff;
      elapsed_in = elapsed_ff;
      wr_en      = 1'b0;
      wr_addr    = cursor_ff[IW-1:0];
      wr_data    = 8'd0;
      walk_start = 1'b0;
      res_ld     = 1'b0;
      res_kind   = KIND_PENDING;
      res_pos    = 4'd0;
      res_char   = 8'd0;
      res_len    = 4'd0;
      res_shown  = 1'b1;
      res_last   = 1'b1;
      if (proc) begin
         if (in_op_ff == OP_TICK) begin
            // ticks only count while a letter is pending; timeout fixes it
            if (pending_ff) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > timeout_ff) begin
                  cursor_in  = cursor_inc;
                  pending_in = 1'b0;
                  prev_in    = NO_KEY;
                  res_ld     = 1'b1;
                  res_kind   = KIND_FIXED;
                  res_pos    = 4'(cursor_ff);
                  res_char   = pend_char;
                  res_len    = 4'(cursor_inc);
               end
            end
         end else if (key_info.valid) begin
            if (key_info.key == KEY_HASH) begin
               // empty name gives the default-name result, else walk the memory
               if (vcount == '0) begin
                  res_ld   = 1'b1;
                  res_kind = KIND_DEFAULT;
               end else begin
                  walk_start = 1'b1;
               end
               cursor_in  = '0;
               pending_in = 1'b0;
               prev_in    = NO_KEY;
               tap_in     = 2'd0;
               elapsed_in = 16'd0;
            end else if (key_info.key == KEY_STAR) begin
               if (pending_ff) begin
                  pending_in = 1'b0;
               end else if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - CW'(1);
               end
               prev_in  = NO_KEY;
               tap_in   = 2'd0;
               res_ld   = 1'b1;
               res_kind = KIND_ERASED;
               res_pos  = 4'(cursor_in);
               res_len  = 4'(cursor_in);
            end else if (pending_ff && key_info.key == prev_ff) begin
               // same key again: next letter of that key, same slot
               tap_in     = tap_next;
               elapsed_in = 16'd0;
               wr_en      = 1'b1;
               wr_data    = tap_letter(prev_ff, tap_next);
               res_ld     = 1'b1;
               res_kind   = KIND_PENDING;
               res_pos    = 4'(cursor_ff);
               res_char   = wr_data;
               res_len    = 4'(cursor_inc);
               res_shown  = 1'b0;
            end else if (pending_ff && cursor_ff == LAST_SLOT) begin
               // fixing the last slot fills the buffer; new letter is dropped
               cursor_in  = cursor_inc;
               pending_in = 1'b0;
               prev_in    = NO_KEY;
               res_ld     = 1'b1;
               res_kind   = KIND_FIXED;
               res_pos    = 4'(cursor_ff);
               res_char   = pend_char;
               res_len    = 4'(cursor_inc);
            end else if (pending_ff) begin
               // different key: fix silently, start a new letter in the next slot
               cursor_in  = cursor_inc;
               prev_in    = key_info.key;
               tap_in     = 2'd0;
               elapsed_in = 16'd0;
               wr_en      = 1'b1;
               wr_addr    = cursor_inc[IW-1:0];
               wr_data    = tap_letter(key_info.key, 2'd0);
               res_ld     = 1'b1;
               res_kind   = KIND_PENDING;
               res_pos    = 4'(cursor_inc);
               res_char   = wr_data;
               res_len    = 4'(cursor_inc + CW'(1));
               res_shown  = 1'b0;
            end else if (cursor_ff < NAME_MAX) begin
               pending_in = 1'b1;
               prev_in    = key_info.key;
               tap_in     = 2'd0;
               elapsed_in = 16'd0;
               wr_en      = 1'b1;
               wr_data    = tap_letter(key_info.key, 2'd0);
               res_ld     = 1'b1;
               res_kind   = KIND_PENDING;
               res_pos    = 4'(cursor_ff);
               res_char   = wr_data;
               res_len    = 4'(cursor_inc);
               res_shown  = 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   logic       out_valid_in;
   logic [2:0] out_kind_ff;
   logic [3:0] out_pos_ff;
   logic [7:0] out_char_ff;
   logic [3:0] out_len_ff;
   logic       out_shown_ff;
   logic       out_last_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_ld || walk_send) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (walk_send) begin
         out_kind_ff  <= KIND_CHAR;
         out_pos_ff   <= 4'(walk_idx_ff);
         out_char_ff  <= rd_data_ff;
         out_len_ff   <= 4'(walk_len_ff);
         out_shown_ff <= 1'b1;
         out_last_ff  <= walk_last;
      end else if (res_ld) begin
         out_kind_ff  <= res_kind;
         out_pos_ff   <= res_pos;
         out_char_ff  <= res_char;
         out_len_ff   <= res_len;
         out_shown_ff <= res_shown;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_shown_ff, out_len_ff, out_char_ff, out_pos_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // a pending letter always sits inside the buffer
   a_pending_in_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (cursor_ff < NAME_MAX))
      else $error("pending letter beyond buffer");

   // the entry is cleared when a walk starts and nothing touches it until it ends
   a_walk_entry_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!pending_ff && cursor_ff == '0))
      else $error("entry changed during name walk");

   // the walk never sends past the stored length
   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (walk_idx_ff < walk_len_ff))
      else $error("walk index past name length");

   // a walk is entered only from an idle processing cycle
   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_READ) && $past(state_ff == ST_IDLE) |-> $past(proc))
      else $error("walk started without an item");
`endif

endmodule
